/* design/sel_pkg.sv */
package sel_pkg;

  localparam int CAPACITY = 64;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_DELETE = 1'b1;

  localparam logic [1:0] STATUS_DONE      = 2'd0;
  localparam logic [1:0] STATUS_FULL      = 2'd1;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

  typedef logic [CNT_W-1:0] cnt_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  node_i;
    logic [7:0]  node_j;
    logic [15:0] cost;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [6:0]  entry_total;
    logic        head_valid;
    logic [7:0]  head_node_i;
    logic [7:0]  head_node_j;
    logic [15:0] head_cost;
  } rsp_t;

  typedef struct packed {
    logic [7:0]  node_i;
    logic [7:0]  node_j;
    logic [15:0] cost;
  } edge_t;

  // operation walking down the cell chain
  // flag: insert still carries a live edge / delete has matched and pulls left
  typedef struct packed {
    logic  vld;
    logic  kind;
    logic  reject;
    logic  flag;
    edge_t carry;
  } tok_t;

endpackage

/* design/sel_cell.sv */
module sel_cell (
  input  logic           clk,
  input  logic           rst,
  input  logic           adv,
  input  logic           occ,
  input  sel_pkg::tok_t  tok_in,
  input  sel_pkg::edge_t right,
  output sel_pkg::tok_t  tok_out,
  output sel_pkg::edge_t slot
);

  sel_pkg::tok_t  tok_next;
  sel_pkg::edge_t slot_next;

  always_comb begin
    tok_next  = tok_in;
    slot_next = slot;
    if (tok_in.vld && !tok_in.reject) begin
      if (tok_in.kind == sel_pkg::KIND_INSERT) begin
        // carried edge goes ahead of equal costs, displaced edge moves on
        if (tok_in.flag && (!occ || slot.cost >= tok_in.carry.cost)) begin
          slot_next      = tok_in.carry;
          tok_next.carry = slot;
          tok_next.flag  = occ;
        end
      end else begin
        if (tok_in.flag || (occ && slot == tok_in.carry)) begin
          slot_next     = right;
          tok_next.flag = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.vld <= 1'b0;
    end else if (adv) begin
      tok_out <= tok_next;
      slot    <= slot_next;
    end
  end

endmodule

/* design/sorted_edge_list_top.sv */
// channel | handshake            | payload
// req     | req_valid, req_stall | req (kind, node_i, node_j, cost)
// rsp     | rsp_valid, rsp_stall | rsp (status, entry_total, head edge)
//
// every item walks the whole chain of CAPACITY cells, one cell per cycle, and the
// result is registered as it leaves the last cell; the next item is taken only
// once that result is registered, so only one item is in the chain at a time.
// rst clears the count, the chain tokens and the result valid; edge slots are
// not cleared. a stalled result freezes the chain while a finished item waits.
module sorted_edge_list_top (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  sel_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output sel_pkg::rsp_t rsp
);

  localparam int N = sel_pkg::CAPACITY;

  logic            busy;
  logic            adv;
  logic            exit_fire;
  sel_pkg::cnt_t   count;
  sel_pkg::cnt_t   count_next;
  sel_pkg::tok_t   tok [N+1];
  sel_pkg::edge_t  slot [N+1];
  logic            occ [N];
  logic [1:0]      status_next;

  assign req_stall = busy;

  always_comb begin
    tok[0].vld          = req_valid && !busy;
    tok[0].kind         = req.kind;
    tok[0].reject       = (req.kind == sel_pkg::KIND_INSERT) &&
                          (count == sel_pkg::cnt_t'(N));
    tok[0].flag         = (req.kind == sel_pkg::KIND_INSERT);
    tok[0].carry.node_i = req.node_i;
    tok[0].carry.node_j = req.node_j;
    tok[0].carry.cost   = req.cost;
  end

  // past the last cell nothing is stored
  assign slot[N] = '0;

  assign adv       = !(tok[N].vld && rsp_valid && rsp_stall);
  assign exit_fire = tok[N].vld && adv;

  for (genvar k = 0; k < N; k++) begin : g_cell
    assign occ[k] = (sel_pkg::cnt_t'(k) < count);

    sel_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .adv     (adv),
      .occ     (occ[k]),
      .tok_in  (tok[k]),
      .right   (slot[k+1]),
      .tok_out (tok[k+1]),
      .slot    (slot[k])
    );
  end

  always_comb begin
    count_next  = count;
    status_next = sel_pkg::STATUS_DONE;
    if (tok[N].reject) begin
      status_next = sel_pkg::STATUS_FULL;
    end else if (tok[N].kind == sel_pkg::KIND_INSERT) begin
      count_next = count + sel_pkg::cnt_t'(1);
    end else if (tok[N].flag) begin
      count_next = count - sel_pkg::cnt_t'(1);
    end else begin
      status_next = sel_pkg::STATUS_NOT_FOUND;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (tok[0].vld) begin
        busy <= 1'b1;
      end else if (exit_fire) begin
        busy <= 1'b0;
      end
      if (exit_fire) begin
        count     <= count_next;
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (exit_fire) begin
      rsp.status      <= status_next;
      rsp.entry_total <= 7'(count_next);
      rsp.head_valid  <= (count_next != '0);
      if (count_next != '0) begin
        rsp.head_node_i <= slot[0].node_i;
        rsp.head_node_j <= slot[0].node_j;
        rsp.head_cost   <= slot[0].cost;
      end else begin
        rsp.head_node_i <= '0;
        rsp.head_node_j <= '0;
        rsp.head_cost   <= '0;
      end
    end
  end

`ifndef SYNTH
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= sel_pkg::cnt_t'(N))
    else $error("entry count above capacity");

  a_rsp_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.entry_total == 7'(count))
    else $error("reported count differs from stored count");

  a_full_reject: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == sel_pkg::STATUS_FULL |-> count == sel_pkg::cnt_t'(N))
    else $error("insert rejected while store not full");

  a_idle_accept: assert property (@(posedge clk) disable iff (rst)
    tok[0].vld |-> !tok[N].vld)
    else $error("item taken while another is in the chain");

  a_exit_frees: assert property (@(posedge clk) disable iff (rst)
    exit_fire |=> !busy)
    else $error("block still busy after result");
`endif

endmodule
